FILE: design/lcdbs_pkg.sv
// Package for the character LCD bus sequencer.
// Holds request codes, register indexes, command bytes, reset values and the phase type.
// No dependencies.
package lcdbs_pkg;

  // Request codes carried on the func field.
  typedef enum logic [2:0] {
    FUNC_DATA   = 3'd0,
    FUNC_CMD    = 3'd1,
    FUNC_GOTO   = 3'd2,
    FUNC_INIT   = 3'd3,
    FUNC_STATUS = 3'd4
  } func_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SETTLE   = 2'd0,
    CFG_RECOVERY = 2'd1,
    CFG_CLEAR    = 2'd2
  } cfg_idx_e;

  // Widths and depths fixed by the interface.
  localparam int unsigned HoldBitsDefault = 16;
  localparam int unsigned HoldPortW       = 16;
  localparam int unsigned MaxPhases       = 4;
  localparam int unsigned PhaseCntW       = $clog2(MaxPhases + 1);
  localparam int unsigned PhaseIdxW       = $clog2(MaxPhases);

  // Register reset values, in 250 ns units.
  localparam logic [15:0] SettleReset   = 16'd32;
  localparam logic [15:0] RecoveryReset = 16'd200;
  localparam logic [15:0] ClearReset    = 16'd8000;

  // Fixed phase lengths.
  localparam logic [1:0] PollHold  = 2'd2;
  localparam logic [0:0] PulseHold = 1'b1;

  // Command bytes and address constants.
  localparam logic [7:0] CmdSetDdram  = 8'h80;
  localparam logic [7:0] Line2Offset  = 8'h40;
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdFuncSet   = 8'b0011_1000;
  localparam logic [7:0] CmdDisplayOn = 8'b0000_1110;
  localparam logic [7:0] CmdEntryMode = 8'b0000_0110;
  localparam logic [2:0] InitSteps    = 3'd4;
  localparam logic [1:0] LineTwo      = 2'd2;

  // Pin settings of one phase; its length travels alongside.
  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic       drv;
    logic [7:0] byte_val;
    logic       samp;
  } phase_t;

  // Command issued at each step of the init sequence.
  function automatic logic [7:0] init_cmd(input logic [1:0] step);
    logic [7:0] cmd;
    unique case (step)
      2'd0:    cmd = CmdFuncSet;
      2'd1:    cmd = CmdDisplayOn;
      2'd2:    cmd = CmdEntryMode;
      default: cmd = CmdClear;
    endcase
    return cmd;
  endfunction

endpackage

FILE: design/lcdbs_cfg_regs.sv
// Configuration registers of the LCD bus sequencer: settle, recovery and clear waits.
// Depends on lcdbs_pkg.
module lcdbs_cfg_regs
  import lcdbs_pkg::*;
#(
  parameter int unsigned HOLD_BITS = HoldBitsDefault,
  localparam int unsigned HoldW    = (HOLD_BITS < HoldPortW) ? HOLD_BITS : HoldPortW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  output logic [HoldW-1:0] settle_o,
  output logic [HoldW-1:0] recovery_o,
  output logic [HoldW-1:0] clear_o
);

  logic [HoldW-1:0] settle_q, recovery_q, clear_q;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= SettleReset[HoldW-1:0];
      recovery_q <= RecoveryReset[HoldW-1:0];
      clear_q    <= ClearReset[HoldW-1:0];
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SETTLE:   settle_q   <= cfg_data_i[HoldW-1:0];
        CFG_RECOVERY: recovery_q <= cfg_data_i[HoldW-1:0];
        CFG_CLEAR:    clear_q    <= cfg_data_i[HoldW-1:0];
        default:      ;
      endcase
    end
  end

  assign settle_o   = settle_q;
  assign recovery_o = recovery_q;
  assign clear_o    = clear_q;

endmodule

FILE: design/lcdbs_seq.sv
// Request sequencer: holds the poll and init state and turns one item into its phase list.
// Depends on lcdbs_pkg.
module lcdbs_seq
  import lcdbs_pkg::*;
#(
  parameter int unsigned HOLD_BITS = HoldBitsDefault,
  localparam int unsigned HoldW    = (HOLD_BITS < HoldPortW) ? HOLD_BITS : HoldPortW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  logic [2:0]                        func_i,
  input  logic [7:0]                        payload_i,
  input  logic [6:0]                        position_i,
  input  logic [1:0]                        display_line_i,
  input  logic [HoldW-1:0]                  settle_i,
  input  logic [HoldW-1:0]                  recovery_i,
  input  logic [HoldW-1:0]                  clear_i,
  output logic [PhaseCntW-1:0]              count_o,
  output phase_t [MaxPhases-1:0]            phases_o,
  output logic [MaxPhases-1:0][HoldW-1:0]   holds_o
);

  logic       waiting_q, waiting_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       pend_data_q, pend_data_d;
  logic [2:0] init_step_q, init_step_d;

  phase_t     poll_ph, settle_ph, pulse_ph, rec_ph, goto_ph;
  logic [7:0] goto_addr;
  logic       rs_pend;

  // Fixed phase shapes.
  always_comb begin
    rs_pend   = pend_data_q;
    poll_ph   = '{rs: 1'b0, rw: 1'b1, en: 1'b1, drv: 1'b0, byte_val: 8'h00, samp: 1'b1};
    settle_ph = '{rs: 1'b0, rw: 1'b1, en: 1'b0, drv: 1'b0, byte_val: 8'h00, samp: 1'b0};
    pulse_ph  = '{rs: rs_pend, rw: 1'b0, en: 1'b1, drv: 1'b1, byte_val: pend_byte_q,
                  samp: 1'b0};
    rec_ph    = pulse_ph;
    rec_ph.en = 1'b0;
    goto_addr = {1'b0, position_i} - 8'd1;
    if (display_line_i == LineTwo) begin
      goto_addr = goto_addr + Line2Offset;
    end
    goto_addr = goto_addr | CmdSetDdram;
    goto_ph   = '{rs: 1'b0, rw: 1'b0, en: 1'b1, drv: 1'b1, byte_val: goto_addr, samp: 1'b0};
  end

  // Next state and the phase list for the item at the head of the input register.
  always_comb begin
    waiting_d   = waiting_q;
    pend_byte_d = pend_byte_q;
    pend_data_d = pend_data_q;
    init_step_d = init_step_q;
    count_o     = '0;
    phases_o    = '0;
    holds_o     = '0;
    if (waiting_q) begin
      if (func_e'(func_i) == FUNC_STATUS) begin
        if (payload_i[7]) begin
          // Still busy: read the status again.
          count_o     = PhaseCntW'(1);
          phases_o[0] = poll_ph;
          holds_o[0]  = HoldW'(PollHold);
        end else begin
          waiting_d   = 1'b0;
          count_o     = PhaseCntW'(3);
          phases_o[0] = settle_ph;
          holds_o[0]  = settle_i;
          phases_o[1] = pulse_ph;
          holds_o[1]  = HoldW'(PulseHold);
          phases_o[2] = rec_ph;
          holds_o[2]  = (!pend_data_q && pend_byte_q == CmdClear) ? clear_i : recovery_i;
          if (init_step_q >= 3'd1 && init_step_q < InitSteps) begin
            // Init continues with its next command.
            pend_byte_d = init_cmd(init_step_q[1:0]);
            init_step_d = init_step_q + 3'd1;
            pend_data_d = 1'b0;
            waiting_d   = 1'b1;
            count_o     = PhaseCntW'(4);
            phases_o[3] = poll_ph;
            holds_o[3]  = HoldW'(PollHold);
          end else begin
            init_step_d = '0;
          end
        end
      end
    end else begin
      unique case (func_e'(func_i))
        FUNC_DATA, FUNC_CMD: begin
          pend_byte_d = payload_i;
          pend_data_d = (func_e'(func_i) == FUNC_DATA);
          waiting_d   = 1'b1;
          count_o     = PhaseCntW'(1);
          phases_o[0] = poll_ph;
          holds_o[0]  = HoldW'(PollHold);
        end
        FUNC_GOTO: begin
          count_o        = PhaseCntW'(2);
          phases_o[0]    = goto_ph;
          holds_o[0]     = HoldW'(PulseHold);
          phases_o[1]    = goto_ph;
          phases_o[1].en = 1'b0;
          holds_o[1]     = HoldW'(PulseHold);
        end
        FUNC_INIT: begin
          init_step_d = 3'd1;
          pend_byte_d = init_cmd(2'd0);
          pend_data_d = 1'b0;
          waiting_d   = 1'b1;
          count_o     = PhaseCntW'(1);
          phases_o[0] = poll_ph;
          holds_o[0]  = HoldW'(PollHold);
        end
        default: ;
      endcase
    end
  end

  // State update when the item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      pend_byte_q <= 8'h00;
      pend_data_q <= 1'b0;
      init_step_q <= '0;
    end else if (advance_i) begin
      waiting_q   <= waiting_d;
      pend_byte_q <= pend_byte_d;
      pend_data_q <= pend_data_d;
      init_step_q <= init_step_d;
    end
  end

endmodule

FILE: design/lcdbs_phase_buf.sv
// Result register for the LCD bus sequencer: holds one item's phases and streams them out.
// Depends on lcdbs_pkg.
module lcdbs_phase_buf
  import lcdbs_pkg::*;
#(
  parameter int unsigned HOLD_BITS = HoldBitsDefault,
  localparam int unsigned HoldW    = (HOLD_BITS < HoldPortW) ? HOLD_BITS : HoldPortW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  output logic                            load_ready_o,
  input  logic [PhaseCntW-1:0]            count_i,
  input  phase_t [MaxPhases-1:0]          phases_i,
  input  logic [MaxPhases-1:0][HoldW-1:0] holds_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output phase_t                          phase_o,
  output logic [HoldW-1:0]                hold_o,
  output logic                            last_o
);

  logic [PhaseCntW-1:0]            cnt_q;
  logic [PhaseIdxW-1:0]            idx_q;
  phase_t [MaxPhases-1:0]          phases_q;
  logic [MaxPhases-1:0][HoldW-1:0] holds_q;
  logic [PhaseCntW-1:0]            cnt_m1;
  logic                            take;

  assign cnt_m1       = cnt_q - PhaseCntW'(1);
  assign out_valid_o  = (cnt_q != '0);
  assign last_o       = (idx_q == cnt_m1[PhaseIdxW-1:0]);
  assign take         = out_valid_o && out_ready_i;
  assign load_ready_o = !out_valid_o || (take && last_o);
  assign phase_o      = phases_q[idx_q];
  assign hold_o       = holds_q[idx_q];

  // Count and read pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= count_i;
      idx_q <= '0;
    end else if (take) begin
      if (last_o) begin
        cnt_q <= '0;
      end else begin
        idx_q <= idx_q + PhaseIdxW'(1);
      end
    end
  end

  // Phase payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      phases_q <= phases_i;
      holds_q  <= holds_i;
    end
  end

endmodule

FILE: design/char_lcd_bus_sequencer.sv
// Top level of the character LCD bus sequencer.
// Depends on lcdbs_pkg, lcdbs_cfg_regs, lcdbs_seq and lcdbs_phase_buf.
//
// Usage: requests (write data, write command, go to position, init) and status samples
// enter on the in channel; pin phases leave on the out channel, up to four per item, each
// with its length in 250 ns units. The receiver drives the pins for that time and, when
// sample_status is set, reads the bus and sends it back as a status item.
// Registers are written on the cfg channel, which is always ready; write them only while
// no request is in flight.
// An accepted item is first held in an input register; its phases are then loaded into a
// result register, from which they are offered on the out channel.
// The result register sends one phase per cycle while the receiver is ready; an item has
// up to four phases, and an item with no phase sends nothing.
// The input register is refilled while the last phase of the previous item is taken.
// Reset: all waits return to their defaults (8 us, 50 us, 2 ms), no poll or init is
// pending and both registers are empty.
// When the receiver stalls, the current phase holds and the input register keeps its
// item, so at most one further item is accepted.
module char_lcd_bus_sequencer
  import lcdbs_pkg::*;
#(
  parameter int unsigned HOLD_BITS = HoldBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  payload_i,
  input  logic [6:0]  position_i,
  input  logic [1:0]  display_line_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic        read_not_write_o,
  output logic        enable_o,
  output logic        drive_bus_o,
  output logic [7:0]  bus_byte_o,
  output logic [15:0] hold_units_o,
  output logic        sample_status_o,
  output logic        last_o
);

  localparam int unsigned HoldW = (HOLD_BITS < HoldPortW) ? HOLD_BITS : HoldPortW;

  logic                            in_valid_q;
  logic [2:0]                      func_q;
  logic [7:0]                      payload_q;
  logic [6:0]                      position_q;
  logic [1:0]                      line_q;
  logic                            advance;
  logic                            buf_ready;
  logic [HoldW-1:0]                settle, recovery, clear_w;
  logic [PhaseCntW-1:0]            count;
  phase_t [MaxPhases-1:0]          phases;
  logic [MaxPhases-1:0][HoldW-1:0] holds;
  phase_t                          cur_phase;
  logic [HoldW-1:0]                cur_hold;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && buf_ready;
  assign in_ready_o  = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q     <= func_i;
      payload_q  <= payload_i;
      position_q <= position_i;
      line_q     <= display_line_i;
    end
  end

  // Configuration registers.
  lcdbs_cfg_regs #(.HOLD_BITS(HOLD_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .settle_o    (settle),
    .recovery_o  (recovery),
    .clear_o     (clear_w)
  );

  // Request decoding and poll state.
  lcdbs_seq #(.HOLD_BITS(HOLD_BITS)) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .func_i         (func_q),
    .payload_i      (payload_q),
    .position_i     (position_q),
    .display_line_i (line_q),
    .settle_i       (settle),
    .recovery_i     (recovery),
    .clear_i        (clear_w),
    .count_o        (count),
    .phases_o       (phases),
    .holds_o        (holds)
  );

  // Result register and phase streaming.
  lcdbs_phase_buf #(.HOLD_BITS(HOLD_BITS)) u_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .load_ready_o (buf_ready),
    .count_i      (count),
    .phases_i     (phases),
    .holds_i      (holds),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phase_o      (cur_phase),
    .hold_o       (cur_hold),
    .last_o       (last_o)
  );

  assign reg_select_o     = cur_phase.rs;
  assign read_not_write_o = cur_phase.rw;
  assign enable_o         = cur_phase.en;
  assign drive_bus_o      = cur_phase.drv;
  assign bus_byte_o       = cur_phase.byte_val;
  assign sample_status_o  = cur_phase.samp;
  assign hold_units_o     = HoldPortW'(cur_hold);

endmodule
